// ----- design/matrix3x3_adjugate_inverse_defines.svh -----
// Assertion macros used by the checker file.
`ifndef MATRIX3X3_ADJUGATE_INVERSE_DEFINES_SVH
`define MATRIX3X3_ADJUGATE_INVERSE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define MIA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mia check failed");

// next-cycle implication
`define MIA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mia check failed");

`endif

// ----- design/mia_pkg.sv -----
// Shared widths, latencies and types for the 3x3 adjugate inverse.
`timescale 1ns / 1ps
package mia_pkg;
  localparam int EW         = 32;                 // entry width
  localparam int PW         = 2 * EW;             // product / minor magnitude width
  localparam int SW         = PW + 2;             // signed minor width
  localparam int DIV_STEPS  = 4;                  // quotient bits per divider stage
  localparam int DIV_STAGES = (EW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int LANE_LAT   = DIV_STAGES + 2;
  localparam int FRONT_LAT  = 4;
  localparam int LAT        = FRONT_LAT + LANE_LAT;

  typedef logic [EW-1:0] mag_t;
  typedef logic [PW-1:0] prod_t;

  typedef struct packed {
    logic neg;    // quotient sign
    logic zero;   // determinant is zero
  } div_ctl_t;
endpackage

// ----- design/mia_div_lane.sv -----
// Pipelined restoring divider for one inverse entry, with saturation.
`timescale 1ns / 1ps
module mia_div_lane import mia_pkg::*; (
  input  logic           clk,
  input  prod_t          num,
  input  mag_t           dmag,
  input  div_ctl_t       ctl,
  output logic [EW-1:0]  quo
);
  mag_t     rem_q [0:DIV_STAGES];
  mag_t     low_q [0:DIV_STAGES];
  mag_t     dm_q  [0:DIV_STAGES];
  div_ctl_t ctl_q [0:DIV_STAGES];
  logic     ovf_q [0:DIV_STAGES];
  mag_t     rem_n [0:DIV_STAGES-1];
  mag_t     low_n [0:DIV_STAGES-1];

  // quotient of 2^EW or more cannot fit: flag it, and the output saturates
  always_ff @(posedge clk) begin
    rem_q[0] <= num[PW-1:EW];
    low_q[0] <= num[EW-1:0];
    dm_q[0]  <= dmag;
    ctl_q[0] <= ctl;
    ovf_q[0] <= (num[PW-1:EW] >= dmag);
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    always_comb begin
      logic [EW:0] t;
      mag_t        r;
      mag_t        l;
      r = rem_q[g];
      l = low_q[g];
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (g * DIV_STEPS + k < EW) begin
          t = {r, l[EW-1]};
          l = {l[EW-2:0], 1'b0};
          if (t >= {1'b0, dm_q[g]}) begin
            t    = t - {1'b0, dm_q[g]};
            l[0] = 1'b1;
          end
          r = t[EW-1:0];
        end
      end
      rem_n[g] = r;
      low_n[g] = l;
    end

    always_ff @(posedge clk) begin
      rem_q[g+1] <= rem_n[g];
      low_q[g+1] <= low_n[g];
      dm_q[g+1]  <= dm_q[g];
      ctl_q[g+1] <= ctl_q[g];
      ovf_q[g+1] <= ovf_q[g];
    end
  end

  localparam mag_t HALF    = {1'b1, {(EW-1){1'b0}}};
  localparam mag_t POS_MAX = {1'b0, {(EW-1){1'b1}}};

  logic [EW-1:0] quo_next;
  mag_t          q;

  always_comb begin
    q = low_q[DIV_STAGES];
    if (ctl_q[DIV_STAGES].zero) begin
      quo_next = '0;
    end else if (ctl_q[DIV_STAGES].neg) begin
      quo_next = (ovf_q[DIV_STAGES] || q > HALF) ? HALF : (~q + 1'b1);
    end else begin
      quo_next = (ovf_q[DIV_STAGES] || q[EW-1]) ? POS_MAX : q;
    end
  end

  always_ff @(posedge clk) begin
    quo <= quo_next;
  end
endmodule

// ----- design/matrix3x3_adjugate_inverse.sv -----
// 3x3 fixed-point matrix inverse by the adjugate, divided by a given determinant.
// Path from start to done: 4 minor stages (A to D), then the divider lane.
// Throughput: one matrix per cycle; busy is never raised.
// The divider retires 4 quotient bits per stage over 8 stages.
// Synchronous active-high rst clears the valid pipeline; data is not reset.
`timescale 1ns / 1ps
module matrix3x3_adjugate_inverse import mia_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [EW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22,
  input  logic [EW-1:0] det,
  output logic          done,
  output logic [EW-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22,
  output logic          singular
);
  logic [EW-1:0] ain [0:8];
  logic [EW-1:0] bq  [0:8];

  assign ain = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};
  assign busy = 1'b0;

  // stage A: sign and magnitude of every entry
  mag_t  mag_a [0:8];
  logic  neg_a [0:8];
  mag_t  dmag_a, dmag_b, dmag_c, dmag_d;
  logic  dneg_a, dneg_b, dneg_c;
  logic  dzero_a, dzero_b, dzero_c, dzero_d;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) begin
      neg_a[i] <= ain[i][EW-1];
      mag_a[i] <= ain[i][EW-1] ? (~ain[i] + 1'b1) : ain[i];
    end
    dneg_a  <= det[EW-1];
    dmag_a  <= det[EW-1] ? (~det + 1'b1) : det;
    dzero_a <= (det == '0);
    dmag_b  <= dmag_a;
    dneg_b  <= dneg_a;
    dzero_b <= dzero_a;
    dmag_c  <= dmag_b;
    dneg_c  <= dneg_b;
    dzero_c <= dzero_b;
    dmag_d  <= dmag_c;
    dzero_d <= dzero_c;
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      localparam int RN = (r + 1) % 3;
      localparam int RP = (r + 2) % 3;
      localparam int CN = (c + 1) % 3;
      localparam int CP = (c + 2) % 3;
      localparam int IP = RN * 3 + CN;
      localparam int IQ = RP * 3 + CP;
      localparam int IR = RN * 3 + CP;
      localparam int IS = RP * 3 + CN;

      prod_t                p1_b, p2_b, mag_d;
      logic                 s1_b, s2_b, neg_d;
      logic signed [SW-1:0] v_c, t1, t2;
      div_ctl_t             ctl_d;

      // stage B: the two products of the minor
      always_ff @(posedge clk) begin
        p1_b <= prod_t'(mag_a[IP]) * prod_t'(mag_a[IQ]);
        p2_b <= prod_t'(mag_a[IR]) * prod_t'(mag_a[IS]);
        s1_b <= neg_a[IP] ^ neg_a[IQ];
        s2_b <= neg_a[IR] ^ neg_a[IS];
      end

      // stage C: signed difference
      assign t1 = s1_b ? -$signed({2'b00, p1_b}) : $signed({2'b00, p1_b});
      assign t2 = s2_b ? -$signed({2'b00, p2_b}) : $signed({2'b00, p2_b});

      always_ff @(posedge clk) begin
        v_c <= t1 - t2;
      end

      // stage D: magnitude and quotient sign
      always_ff @(posedge clk) begin
        neg_d <= v_c[SW-1] ^ dneg_c;
        mag_d <= v_c[SW-1] ? PW'(-v_c) : v_c[PW-1:0];
      end

      assign ctl_d = '{neg: neg_d, zero: dzero_d};

      mia_div_lane u_div (
        .clk  (clk),
        .num  (mag_d),
        .dmag (dmag_d),
        .ctl  (ctl_d),
        .quo  (bq[c*3+r])
      );
    end
  end

  logic [LAT-1:0] vld;
  logic [LAT-1:0] sing;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
    sing <= {sing[LAT-2:0], (det == '0)};
  end

  assign done     = vld[LAT-1];
  assign singular = sing[LAT-1];
  assign b00 = bq[0];
  assign b01 = bq[1];
  assign b02 = bq[2];
  assign b10 = bq[3];
  assign b11 = bq[4];
  assign b12 = bq[5];
  assign b20 = bq[6];
  assign b21 = bq[7];
  assign b22 = bq[8];
endmodule

// ----- design/mia_checker.sv -----
// Port-level checks for the adjugate inverse, bound to the top level.
`timescale 1ns / 1ps
`include "matrix3x3_adjugate_inverse_defines.svh"
module mia_checker import mia_pkg::*; (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input logic          singular,
  input logic [EW-1:0] b00,
  input logic [EW-1:0] b11,
  input logic [EW-1:0] b22
);
  // every accepted beat is matched by done at the end of the pipeline, and each done by an earlier accepted beat
  `MIA_ASSERT_NOW(a_start_done, start && !busy, ##LAT done)
  `MIA_ASSERT_NOW(a_done_start, done, $past(start && !busy, LAT))
  // a singular result carries zero entries
  `MIA_ASSERT_NOW(a_sing_zero, done && singular, b00 == '0 && b11 == '0 && b22 == '0)
  `MIA_ASSERT_NEXT(a_no_busy, 1'b1, !busy)
endmodule

bind matrix3x3_adjugate_inverse mia_checker u_mia_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .singular (singular),
  .b00      (b00),
  .b11      (b11),
  .b22      (b22)
);
